FILE: hdl/tkh_pkg.sv
// ---------------------------------------------------------------------------
// tkh_pkg: shared types and constants of the top-k min-heap selector
// command codes, sequencer states and the structs between sub-blocks
// ---------------------------------------------------------------------------
package tkh_pkg;

  // command codes carried on in_tuser
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DRAIN  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam int IdW    = 32;
  localparam int ScoreW = 32;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_DRN_RD,
    ST_DRN_SWP,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_OUT_RD,
    ST_OUT_LD
  } seq_state_t;

  // decision of the shared compare unit
  typedef struct packed {
    logic move;      // node must move down (or candidate beats root)
    logic go_right;  // right child is the one to promote
  } sift_dec_t;

  // word handed from the sequencer to the output register
  typedef struct packed {
    logic              vld;
    logic              last;
    logic [IdW-1:0]    id;
    logic [ScoreW-1:0] score;
  } emit_t;

endpackage

FILE: hdl/tkh_store.sv
// ---------------------------------------------------------------------------
// tkh_store: heap slot memory
// one write port, two registered read ports, per-slot valid bits so that
// an unwritten or cleared slot reads as id 0 and score 0
// ---------------------------------------------------------------------------
module tkh_store import tkh_pkg::*; #(
  parameter int ENTRIES = 16,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [IdW-1:0]    wid,
  input  logic [ScoreW-1:0] wscore,
  input  logic [AW-1:0]     raddr_a,
  input  logic [AW-1:0]     raddr_b,
  output logic [IdW-1:0]    rid_a,
  output logic [ScoreW-1:0] rscore_a,
  output logic [IdW-1:0]    rid_b,
  output logic [ScoreW-1:0] rscore_b
);

  logic [IdW-1:0]    mem_id    [ENTRIES];
  logic [ScoreW-1:0] mem_score [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  logic [IdW-1:0]    rd_id_a_r, rd_id_b_r;
  logic [ScoreW-1:0] rd_sc_a_r, rd_sc_b_r;
  logic              rd_vld_a_r, rd_vld_b_r;

  // slot memory write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_id[waddr]    <= wid;
      mem_score[waddr] <= wscore;
    end
  end

  // valid bits, cleared at once by reset or a store clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clr) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  // registered reads on both ports
  always_ff @(posedge clk) begin
    rd_id_a_r <= mem_id[raddr_a];
    rd_sc_a_r <= mem_score[raddr_a];
    rd_id_b_r <= mem_id[raddr_b];
    rd_sc_b_r <= mem_score[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_a_r <= 1'b0;
      rd_vld_b_r <= 1'b0;
    end else begin
      rd_vld_a_r <= valid_r[raddr_a];
      rd_vld_b_r <= valid_r[raddr_b];
    end
  end

  // empty slots read as zero
  assign rid_a    = rd_vld_a_r ? rd_id_a_r : '0;
  assign rscore_a = rd_vld_a_r ? rd_sc_a_r : '0;
  assign rid_b    = rd_vld_b_r ? rd_id_b_r : '0;
  assign rscore_b = rd_vld_b_r ? rd_sc_b_r : '0;

endmodule

FILE: hdl/tkh_cmp.sv
// ---------------------------------------------------------------------------
// tkh_cmp: shared signed score compare unit
// decides one sift-down level, and the candidate-versus-root test on insert
// ---------------------------------------------------------------------------
module tkh_cmp import tkh_pkg::*; (
  input  logic [ScoreW-1:0] cur_score,
  input  logic [ScoreW-1:0] left_score,
  input  logic [ScoreW-1:0] right_score,
  input  logic              left_in,
  input  logic              right_in,
  output sift_dec_t         dec
);

  logic l_lt_cur, r_lt_cur, r_lt_l;

  // signed Q16.16 compares
  assign l_lt_cur = $signed(left_score)  < $signed(cur_score);
  assign r_lt_cur = $signed(right_score) < $signed(cur_score);
  assign r_lt_l   = $signed(right_score) < $signed(left_score);

  // smaller child wins, ties go left
  always_comb begin
    dec = '0;
    if (left_in && !right_in) begin
      dec.move = l_lt_cur;
    end else if (left_in && right_in) begin
      dec.move     = l_lt_cur || r_lt_cur;
      dec.go_right = r_lt_l;
    end
  end

endmodule

FILE: hdl/tkh_seq.sv
// ---------------------------------------------------------------------------
// tkh_seq: command sequencer
// runs insert, heap-sort drain and clear over the slot memory; each sift-down
// level is a read state and a compare state using the shared compare unit
// ---------------------------------------------------------------------------
module tkh_seq import tkh_pkg::*; #(
  parameter int ENTRIES = 16,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic              clk,
  input  logic              rst_n,
  // command word
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  logic [1:0]        cmd,
  input  logic [IdW-1:0]    cmd_id,
  input  logic [ScoreW-1:0] cmd_score,
  // result word
  input  logic              emit_free,
  output emit_t             emit
);

  localparam int CW = AW + 2;
  localparam logic [AW:0]   SpanFull = (AW+1)'(ENTRIES);
  localparam logic [AW-1:0] LastIdx  = AW'(ENTRIES - 1);

  seq_state_t state_r, state_nxt;

  logic [IdW-1:0]    cur_id_r, cur_id_nxt;
  logic [ScoreW-1:0] cur_sc_r, cur_sc_nxt;
  logic [AW-1:0]     node_r, node_nxt;
  logic [AW:0]       span_r, span_nxt;
  logic [AW-1:0]     end_r, end_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic              drain_r, drain_nxt;

  logic              accept;
  logic [CW-1:0]     lc, rc;
  logic              l_in, r_in;

  // memory port signals
  logic              clr, we;
  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  logic [IdW-1:0]    wid, rid_a, rid_b;
  logic [ScoreW-1:0] wscore, rscore_a, rscore_b;

  // compare unit signals
  logic [ScoreW-1:0] cmp_cur;
  logic              cmp_l_in, cmp_r_in;
  sift_dec_t         dec;

  assign accept = cmd_valid && cmd_ready;

  // child slots of the current node and whether they lie inside the span
  assign lc   = {1'b0, node_r, 1'b1};
  assign rc   = lc + CW'(1);
  assign l_in = lc < CW'(span_r);
  assign r_in = rc < CW'(span_r);

  tkh_store #(.ENTRIES(ENTRIES)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (clr),
    .we       (we),
    .waddr    (waddr),
    .wid      (wid),
    .wscore   (wscore),
    .raddr_a  (raddr_a),
    .raddr_b  (raddr_b),
    .rid_a    (rid_a),
    .rscore_a (rscore_a),
    .rid_b    (rid_b),
    .rscore_b (rscore_b)
  );

  tkh_cmp u_cmp (
    .cur_score   (cmp_cur),
    .left_score  (rscore_a),
    .right_score (rscore_b),
    .left_in     (cmp_l_in),
    .right_in    (cmp_r_in),
    .dec         (dec)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && cmd == CMD_INSERT) begin
          state_nxt = ST_INS_RD;
        end else if (accept && cmd == CMD_DRAIN) begin
          state_nxt = ST_DRN_RD;
        end
      end
      ST_INS_RD:  state_nxt = ST_INS_CMP;
      ST_INS_CMP: state_nxt = dec.move ? ST_SIFT_RD : ST_IDLE;
      ST_DRN_RD:  state_nxt = ST_DRN_SWP;
      ST_DRN_SWP: state_nxt = ST_SIFT_RD;
      ST_SIFT_RD: state_nxt = ST_SIFT_CMP;
      ST_SIFT_CMP: begin
        if (dec.move) begin
          state_nxt = ST_SIFT_RD;
        end else if (!drain_r) begin
          state_nxt = ST_IDLE;
        end else if (end_r == '0) begin
          state_nxt = ST_OUT_RD;
        end else begin
          state_nxt = ST_DRN_RD;
        end
      end
      ST_OUT_RD: state_nxt = ST_OUT_LD;
      ST_OUT_LD: begin
        if (emit_free) begin
          state_nxt = (idx_r == LastIdx) ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: memory port, compare unit inputs, result word
  always_comb begin
    cmd_ready = (state_r == ST_IDLE);
    clr       = 1'b0;
    we        = 1'b0;
    waddr     = node_r;
    wid       = cur_id_r;
    wscore    = cur_sc_r;
    raddr_a   = '0;
    raddr_b   = '0;
    cmp_cur   = cur_sc_r;
    cmp_l_in  = 1'b0;
    cmp_r_in  = 1'b0;
    emit      = '0;
    case (state_r)
      ST_IDLE: begin
        clr = accept && cmd == CMD_CLEAR;
      end
      ST_INS_CMP: begin
        // root against candidate
        cmp_l_in = 1'b1;
      end
      ST_DRN_RD: begin
        raddr_b = end_r;
      end
      ST_DRN_SWP: begin
        // old root goes to the end of the heap
        we     = 1'b1;
        waddr  = end_r;
        wid    = rid_a;
        wscore = rscore_a;
      end
      ST_SIFT_RD: begin
        raddr_a = l_in ? lc[AW-1:0] : '0;
        raddr_b = r_in ? rc[AW-1:0] : '0;
      end
      ST_SIFT_CMP: begin
        cmp_l_in = l_in;
        cmp_r_in = r_in;
        we       = 1'b1;
        if (dec.move) begin
          // promote the chosen child into the node
          wid    = dec.go_right ? rid_b    : rid_a;
          wscore = dec.go_right ? rscore_b : rscore_a;
        end
      end
      ST_OUT_RD: begin
        raddr_a = idx_r;
      end
      ST_OUT_LD: begin
        raddr_a    = idx_r;
        emit.vld   = emit_free;
        emit.last  = (idx_r == LastIdx);
        emit.id    = rid_a;
        emit.score = rscore_a;
        clr        = emit_free && (idx_r == LastIdx);
      end
      default: begin
        raddr_a = '0;
      end
    endcase
  end

  // datapath register updates
  always_comb begin
    cur_id_nxt = cur_id_r;
    cur_sc_nxt = cur_sc_r;
    node_nxt   = node_r;
    span_nxt   = span_r;
    end_nxt    = end_r;
    idx_nxt    = idx_r;
    drain_nxt  = drain_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && cmd == CMD_INSERT) begin
          cur_id_nxt = cmd_id;
          cur_sc_nxt = cmd_score;
          drain_nxt  = 1'b0;
        end else if (accept && cmd == CMD_DRAIN) begin
          drain_nxt = 1'b1;
          end_nxt   = LastIdx;
        end
      end
      ST_INS_CMP: begin
        node_nxt = '0;
        span_nxt = SpanFull;
      end
      ST_DRN_SWP: begin
        cur_id_nxt = rid_b;
        cur_sc_nxt = rscore_b;
        node_nxt   = '0;
        span_nxt   = {1'b0, end_r};
      end
      ST_SIFT_CMP: begin
        if (dec.move) begin
          node_nxt = dec.go_right ? rc[AW-1:0] : lc[AW-1:0];
        end else if (drain_r && end_r == '0) begin
          idx_nxt = '0;
        end else if (drain_r) begin
          end_nxt = end_r - AW'(1);
        end
      end
      ST_OUT_LD: begin
        if (emit_free) begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      drain_r <= 1'b0;
      end_r   <= '0;
      idx_r   <= '0;
      node_r  <= '0;
      span_r  <= '0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
      end_r   <= end_nxt;
      idx_r   <= idx_nxt;
      node_r  <= node_nxt;
      span_r  <= span_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_id_r <= cur_id_nxt;
    cur_sc_r <= cur_sc_nxt;
  end

endmodule

FILE: hdl/top_k_min_heap_selector.sv
// ---------------------------------------------------------------------------
// top_k_min_heap_selector: keeps the ENTRIES highest-scoring (id, score)
// pairs in a binary min-heap and drains them sorted, highest score first
// ---------------------------------------------------------------------------
// in channel: in_tuser selects the command (insert, drain, clear), in_tdata
//   carries the candidate id and signed Q16.16 score used by insert.
// out channel: one word per heap slot during a drain, out_tlast on the
//   final word; ENTRIES words per drain, empty slots read as id 0 score 0.
// insert: the root is read, then compared with the candidate; a dropped
//   candidate ends there, an accepted one then sifts down one level per
//   read and compare state pair, up to floor(log2(ENTRIES)) + 1 levels.
//   The single compare unit and the registered memory reads set that pace.
// clear: done in the cycle of acceptance, ready again the next cycle.
// drain: heap sort of ENTRIES passes, each a read and a swap plus a sift-down,
//   then a read and a load per emitted word; the store is empty afterwards.
// in_tready is high only while no command is in progress.
// reset: the store reads as all zero at once, the output word is dropped.
// a stalled receiver holds the current word; the drain waits for it.
// ---------------------------------------------------------------------------
module top_k_min_heap_selector import tkh_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // item_id [31:0], score [63:32]
  input  logic [1:0]  in_tuser,   // command [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_id [31:0], out_score [63:32]
  output logic        out_tlast
);

  emit_t emit;
  logic  emit_free;

  logic              out_vld_r;
  logic              out_last_r;
  logic [IdW-1:0]    out_id_r;
  logic [ScoreW-1:0] out_sc_r;

  tkh_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (in_tuser),
    .cmd_id    (in_tdata[31:0]),
    .cmd_score (in_tdata[63:32]),
    .emit_free (emit_free),
    .emit      (emit)
  );

  // output word register, free when empty or being taken
  assign emit_free = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit.vld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.vld) begin
      out_last_r <= emit.last;
      out_id_r   <= emit.id;
      out_sc_r   <= emit.score;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_sc_r, out_id_r};
  assign out_tlast  = out_last_r;

  // no word is produced while a command can be taken
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit.vld |-> !in_tready)
    else $error("word emitted while idle");

  // a pending word is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit.vld |-> (!out_vld_r || out_tready))
    else $error("output word overwritten");

  // a clear finishes in the cycle it is taken
  a_clear_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == CMD_CLEAR) |=> in_tready)
    else $error("clear did not return to idle");

  // after the final word of a drain the block is idle again
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.vld && emit.last) |=> in_tready)
    else $error("not idle after drain");

endmodule
